>>> design/calendar_and_uptime_clock_unit_macros.svh
// Assertion macros used by the calendar and uptime clock top level.
`ifndef CALENDAR_AND_UPTIME_CLOCK_UNIT_MACROS_SVH
`define CALENDAR_AND_UPTIME_CLOCK_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CAUC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CAUC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/cauc_pkg.sv
// Shared constants, types and the month length table of the calendar clock.
`timescale 1ns / 1ps

package cauc_pkg;

    localparam int unsigned MS_PER_SEC     = 1000;
    localparam int unsigned SEC_PER_MIN    = 60;
    localparam int unsigned MIN_PER_HOUR   = 60;
    localparam int unsigned HOUR_PER_DAY   = 24;
    localparam int unsigned LEAP_FEB_LIMIT = 30;

    // floor(m / 1000) == (m * RECIP_1000) >> DIV_SHIFT for every m below 2^17
    localparam int unsigned DIV_SHIFT  = 27;
    localparam logic [17:0] RECIP_1000 = 18'd134218;

    localparam logic [15:0] RESET_YEAR  = 16'd2023;
    localparam logic [3:0]  MONTH_JAN   = 4'd1;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_MAR   = 4'd3;
    localparam logic [3:0]  MONTH_WRAP  = 4'd13;
    localparam logic [4:0]  FIRST_DAY   = 5'd1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // time of day below the day level
    typedef struct packed {
        logic [9:0] ms;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
    } t_tod;

    // Days in a month; a month code outside one to twelve counts as 31 days.
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> design/calendar_and_uptime_clock_unit.sv
// Top level of the calendar clock and uptime counter.
`timescale 1ns / 1ps
//
//  channel  | signals                            | moves
//  ---------+------------------------------------+------------------------------
//  request  | i_valid / o_ready, i_cmd, i_delta_ms, i_set_* | tick or calendar load
//  result   | o_valid / i_ready, o_now_*, o_run_*            | both clocks after request
//
//  One request per cycle sustained while i_ready is high; a result is valid once its
//  request has passed the input register, then the clock registers (the result register).
//  The whole carry chain and date rollover is one pass of logic between those registers.
//  Reset (i_rst_n low, synchronous) loads 2023-01-01 00:00:00.000 and zero uptime.
//  A stalled result holds the clocks; one further request waits in the input register.

`include "calendar_and_uptime_clock_unit_macros.svh"

module calendar_and_uptime_clock_unit
    import cauc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_delta_ms,
    input  logic [15:0] i_set_year,
    input  logic [3:0]  i_set_month,
    input  logic [4:0]  i_set_day,
    input  logic [4:0]  i_set_hour,
    input  logic [5:0]  i_set_minute,
    input  logic [5:0]  i_set_second,
    input  logic [9:0]  i_set_millisecond,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_now_year,
    output logic [3:0]  o_now_month,
    output logic [4:0]  o_now_day,
    output logic [4:0]  o_now_hour,
    output logic [5:0]  o_now_minute,
    output logic [5:0]  o_now_second,
    output logic [9:0]  o_now_millisecond,
    output logic [15:0] o_run_days,
    output logic [4:0]  o_run_hours,
    output logic [5:0]  o_run_minutes,
    output logic [5:0]  o_run_seconds,
    output logic [9:0]  o_run_milliseconds
);

    // input register
    logic        r_in_valid;
    logic        r_cmd;
    logic [15:0] r_delta;
    logic [15:0] r_set_year;
    logic [3:0]  r_set_month;
    logic [4:0]  r_set_day;
    t_tod        r_set_tod;

    // clock state, also the result register
    logic        r_out_valid;
    logic [15:0] r_cal_year;
    logic [3:0]  r_cal_month;
    logic [4:0]  r_cal_day;
    t_tod        r_cal_tod;
    logic [15:0] r_up_days;
    t_tod        r_up_tod;

    logic        w_adv;
    logic        w_take;
    logic        w_accept;

    t_tod        w_cal_tod;
    logic        w_cal_carry;
    t_tod        w_up_tod;
    logic        w_up_carry;

    logic [5:0]  w_day_inc;
    logic        w_leap_feb;
    logic        w_roll;
    logic [3:0]  w_month_rolled;
    logic [15:0] n_cal_year;
    logic [3:0]  n_cal_month;
    logic [4:0]  n_cal_day;

    assign w_adv    = !r_out_valid || i_ready;
    assign w_take   = r_in_valid && w_adv;
    assign o_ready  = !r_in_valid || w_adv;
    assign w_accept = i_valid && o_ready;

    cauc_carry u_cal_carry (
        .i_tod       (r_cal_tod),
        .i_delta     (r_delta),
        .o_tod       (w_cal_tod),
        .o_day_carry (w_cal_carry)
    );

    cauc_carry u_up_carry (
        .i_tod       (r_up_tod),
        .i_delta     (r_delta),
        .o_tod       (w_up_tod),
        .o_day_carry (w_up_carry)
    );

    // date rollover on a day carry
    assign w_day_inc  = {1'b0, r_cal_day} + 6'd1;
    assign w_leap_feb = (r_cal_year[1:0] == 2'b00) && (r_cal_month == MONTH_FEB);

    always_comb begin
        if (w_leap_feb) begin
            w_roll         = (w_day_inc >= 6'(LEAP_FEB_LIMIT));
            w_month_rolled = MONTH_MAR;
        end else begin
            w_roll         = (w_day_inc > {1'b0, month_days(r_cal_month)});
            w_month_rolled = r_cal_month + 4'd1;
        end
    end

    always_comb begin
        n_cal_year  = r_cal_year;
        n_cal_month = r_cal_month;
        n_cal_day   = r_cal_day;
        if (w_cal_carry) begin
            n_cal_day = w_day_inc[4:0];
            if (w_roll) begin
                n_cal_day   = FIRST_DAY;
                n_cal_month = w_month_rolled;
            end
            // month 13 wraps here, whether rolled from 12 or loaded as 13 with no day rollover
            if (n_cal_month == MONTH_WRAP) begin
                n_cal_month = MONTH_JAN;
                n_cal_year  = r_cal_year + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd         <= i_cmd;
            r_delta       <= i_delta_ms;
            r_set_year    <= i_set_year;
            r_set_month   <= i_set_month;
            r_set_day     <= i_set_day;
            r_set_tod.ms  <= i_set_millisecond;
            r_set_tod.sec <= i_set_second;
            r_set_tod.min <= i_set_minute;
            r_set_tod.hr  <= i_set_hour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cal_year  <= RESET_YEAR;
            r_cal_month <= MONTH_JAN;
            r_cal_day   <= FIRST_DAY;
            r_cal_tod   <= '0;
            r_up_days   <= '0;
            r_up_tod    <= '0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                unique case (r_cmd)
                    CMD_TICK: begin
                        r_cal_year  <= n_cal_year;
                        r_cal_month <= n_cal_month;
                        r_cal_day   <= n_cal_day;
                        r_cal_tod   <= w_cal_tod;
                        r_up_days   <= r_up_days + {15'b0, w_up_carry};
                        r_up_tod    <= w_up_tod;
                    end
                    CMD_SET: begin
                        r_cal_year  <= r_set_year;
                        r_cal_month <= r_set_month;
                        r_cal_day   <= r_set_day;
                        r_cal_tod   <= r_set_tod;
                    end
                    default: begin
                    end
                endcase
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_now_year         = r_cal_year;
    assign o_now_month        = r_cal_month;
    assign o_now_day          = r_cal_day;
    assign o_now_hour         = r_cal_tod.hr;
    assign o_now_minute       = r_cal_tod.min;
    assign o_now_second       = r_cal_tod.sec;
    assign o_now_millisecond  = r_cal_tod.ms;
    assign o_run_days         = r_up_days;
    assign o_run_hours        = r_up_tod.hr;
    assign o_run_minutes      = r_up_tod.min;
    assign o_run_seconds      = r_up_tod.sec;
    assign o_run_milliseconds = r_up_tod.ms;

    `CAUC_ASSERT_NEXT(a_held_request_kept, r_in_valid && !w_adv, r_in_valid, "request lost")
    `CAUC_ASSERT_NOW(a_result_from_take, $rose(o_valid), $past(w_take), "result without request")
    `CAUC_ASSERT_NEXT(a_set_keeps_uptime, w_take && (r_cmd == CMD_SET), $stable(r_up_tod) && $stable(r_up_days), "load changed uptime")
    `CAUC_ASSERT_NEXT(a_roll_first_day, w_take && (r_cmd == CMD_TICK) && w_cal_carry && w_roll, r_cal_day == FIRST_DAY, "month rollover missed day one")

endmodule

>>> design/cauc_carry.sv
// Millisecond to day carry chain shared by the calendar and uptime clocks.
`timescale 1ns / 1ps

module cauc_carry
    import cauc_pkg::*;
(
    input  t_tod        i_tod,
    input  logic [15:0] i_delta,
    output t_tod        o_tod,
    output logic        o_day_carry
);

    logic [16:0] w_m;
    logic [34:0] w_prod;
    logic [6:0]  w_q;
    logic [16:0] w_q1000;
    logic [16:0] w_rem;
    logic [7:0]  w_s;
    logic [7:0]  w_s_red;
    logic [1:0]  w_qs;
    logic [6:0]  w_mn;
    logic [5:0]  w_h;

    assign w_m     = {7'b0, i_tod.ms} + {1'b0, i_delta};
    assign w_prod  = {18'b0, w_m} * {17'b0, RECIP_1000};
    assign w_q     = w_prod[DIV_SHIFT+6:DIV_SHIFT];
    // q * 1000 as q * (1024 - 16 - 8)
    assign w_q1000 = {w_q, 10'b0} - {6'b0, w_q, 4'b0} - {7'b0, w_q, 3'b0};
    assign w_rem   = w_m - w_q1000;

    // seconds reach at most 63 + 66, so the carry into minutes is 0, 1 or 2
    assign w_s = {2'b0, i_tod.sec} + {1'b0, w_q};
    always_comb begin
        if (w_s >= 8'(2 * SEC_PER_MIN)) begin
            w_qs    = 2'd2;
            w_s_red = w_s - 8'(2 * SEC_PER_MIN);
        end else if (w_s >= 8'(SEC_PER_MIN)) begin
            w_qs    = 2'd1;
            w_s_red = w_s - 8'(SEC_PER_MIN);
        end else begin
            w_qs    = 2'd0;
            w_s_red = w_s;
        end
    end

    assign w_mn = {1'b0, i_tod.min} + {5'b0, w_qs};
    assign w_h  = {1'b0, i_tod.hr} + 6'd1;

    // each level is rewritten only when the level below it carried
    always_comb begin
        o_tod       = i_tod;
        o_day_carry = 1'b0;
        if (w_m < 17'(MS_PER_SEC)) begin
            o_tod.ms = w_m[9:0];
        end else begin
            o_tod.ms = w_rem[9:0];
            if (w_s < 8'(SEC_PER_MIN)) begin
                o_tod.sec = w_s[5:0];
            end else begin
                o_tod.sec = w_s_red[5:0];
                if (w_mn < 7'(MIN_PER_HOUR)) begin
                    o_tod.min = w_mn[5:0];
                end else begin
                    o_tod.min = 6'(w_mn - 7'(MIN_PER_HOUR));
                    if (w_h < 6'(HOUR_PER_DAY)) begin
                        o_tod.hr = w_h[4:0];
                    end else begin
                        o_tod.hr    = 5'(w_h - 6'(HOUR_PER_DAY));
                        o_day_carry = 1'b1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_calendar_and_uptime_clock_unit.sv
// Self-checking testbench for the calendar clock and uptime counter unit.
`timescale 1ns / 1ps

module tb_calendar_and_uptime_clock_unit;
    import cauc_pkg::*;

    localparam int unsigned RANDOM_REQUESTS = 850;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned DRAIN_CYCLES    = 10;

    typedef struct packed {
        logic        cmd;
        logic [15:0] delta_ms;
        logic [15:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
        logic [9:0]  set_millisecond;
    } t_clock_request;

    typedef struct packed {
        logic [15:0] now_year;
        logic [3:0]  now_month;
        logic [4:0]  now_day;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [5:0]  now_second;
        logic [9:0]  now_millisecond;
        logic [15:0] run_days;
        logic [4:0]  run_hours;
        logic [5:0]  run_minutes;
        logic [5:0]  run_seconds;
        logic [9:0]  run_milliseconds;
    } t_clock_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = CMD_TICK;
    logic [15:0] i_delta_ms = '0;
    logic [15:0] i_set_year = '0;
    logic [3:0]  i_set_month = '0;
    logic [4:0]  i_set_day = '0;
    logic [4:0]  i_set_hour = '0;
    logic [5:0]  i_set_minute = '0;
    logic [5:0]  i_set_second = '0;
    logic [9:0]  i_set_millisecond = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_now_year;
    logic [3:0]  o_now_month;
    logic [4:0]  o_now_day;
    logic [4:0]  o_now_hour;
    logic [5:0]  o_now_minute;
    logic [5:0]  o_now_second;
    logic [9:0]  o_now_millisecond;
    logic [15:0] o_run_days;
    logic [4:0]  o_run_hours;
    logic [5:0]  o_run_minutes;
    logic [5:0]  o_run_seconds;
    logic [9:0]  o_run_milliseconds;

    calendar_and_uptime_clock_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_delta_ms         (i_delta_ms),
        .i_set_year         (i_set_year),
        .i_set_month        (i_set_month),
        .i_set_day          (i_set_day),
        .i_set_hour         (i_set_hour),
        .i_set_minute       (i_set_minute),
        .i_set_second       (i_set_second),
        .i_set_millisecond  (i_set_millisecond),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_now_year         (o_now_year),
        .o_now_month        (o_now_month),
        .o_now_day          (o_now_day),
        .o_now_hour         (o_now_hour),
        .o_now_minute       (o_now_minute),
        .o_now_second       (o_now_second),
        .o_now_millisecond  (o_now_millisecond),
        .o_run_days         (o_run_days),
        .o_run_hours        (o_run_hours),
        .o_run_minutes      (o_run_minutes),
        .o_run_seconds      (o_run_seconds),
        .o_run_milliseconds (o_run_milliseconds)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted clock state
    logic [15:0] cal_year = RESET_YEAR;
    logic [3:0]  cal_month = MONTH_JAN;
    logic [4:0]  cal_day = FIRST_DAY;
    logic [4:0]  cal_hour = '0;
    logic [5:0]  cal_minute = '0;
    logic [5:0]  cal_second = '0;
    logic [9:0]  cal_ms = '0;
    logic [15:0] up_days = '0;
    logic [4:0]  up_hours = '0;
    logic [5:0]  up_minutes = '0;
    logic [5:0]  up_seconds = '0;
    logic [9:0]  up_ms = '0;

    t_clock_request requests_pending[$];
    t_clock_reading clock_readings_due[$];
    t_clock_request request_on_bus;

    int unsigned total_requests = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned n_cycles = 0;
    int unsigned n_ticks = 0;
    int unsigned n_sets = 0;
    int unsigned n_day_rolls = 0;
    int unsigned n_month_rolls = 0;
    int unsigned n_year_rolls = 0;
    int unsigned n_leap_days = 0;

    // nominal month length; codes outside one to twelve count as 31 days
    function automatic int unsigned month_length(input int unsigned month);
        case (month)
            2:           return 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // ms -> s -> min -> h -> day; stops at the first level that does not overflow
    function automatic bit ripple_to_days(inout int unsigned ms, inout int unsigned sec,
                                          inout int unsigned mn, inout int unsigned hr,
                                          inout int unsigned dy, input int unsigned delta);
        ms = ms + delta;
        if (ms < MS_PER_SEC) return 1'b0;
        sec = sec + ms / MS_PER_SEC;
        ms = ms % MS_PER_SEC;
        if (sec < SEC_PER_MIN) return 1'b0;
        mn = mn + sec / SEC_PER_MIN;
        sec = sec % SEC_PER_MIN;
        if (mn < MIN_PER_HOUR) return 1'b0;
        hr = hr + mn / MIN_PER_HOUR;
        mn = mn % MIN_PER_HOUR;
        if (hr < HOUR_PER_DAY) return 1'b0;
        dy = dy + hr / HOUR_PER_DAY;
        hr = hr % HOUR_PER_DAY;
        return 1'b1;
    endfunction

    function automatic t_clock_reading advance_clocks(input t_clock_request req);
        int unsigned ms, sec, mn, hr, dy, mo, yr;
        bit day_up;
        t_clock_reading rd;
        if (req.cmd == CMD_TICK) begin
            n_ticks++;
            ms = 32'(up_ms);
            sec = 32'(up_seconds);
            mn = 32'(up_minutes);
            hr = 32'(up_hours);
            dy = 32'(up_days);
            void'(ripple_to_days(ms, sec, mn, hr, dy, 32'(req.delta_ms)));
            up_ms = ms[9:0];
            up_seconds = sec[5:0];
            up_minutes = mn[5:0];
            up_hours = hr[4:0];
            up_days = dy[15:0];

            ms = 32'(cal_ms);
            sec = 32'(cal_second);
            mn = 32'(cal_minute);
            hr = 32'(cal_hour);
            dy = 32'(cal_day);
            mo = 32'(cal_month);
            yr = 32'(cal_year);
            day_up = ripple_to_days(ms, sec, mn, hr, dy, 32'(req.delta_ms));
            if (day_up) begin
                n_day_rolls++;
                if (yr[1:0] == 2'd0 && mo == 32'(MONTH_FEB)) begin
                    if (dy >= LEAP_FEB_LIMIT) begin
                        dy = 32'(FIRST_DAY);
                        mo = mo + 1;
                        n_month_rolls++;
                    end else if (dy == LEAP_FEB_LIMIT - 1) begin
                        n_leap_days++;
                    end
                end else if (dy > month_length(mo)) begin
                    dy = 32'(FIRST_DAY);
                    mo = (mo + 1) & 32'hF;
                    n_month_rolls++;
                end
                if (mo == 32'(MONTH_WRAP)) begin
                    mo = 32'(MONTH_JAN);
                    yr = (yr + 1) & 32'hFFFF;
                    n_year_rolls++;
                end
            end
            cal_ms = ms[9:0];
            cal_second = sec[5:0];
            cal_minute = mn[5:0];
            cal_hour = hr[4:0];
            cal_day = dy[4:0];
            cal_month = mo[3:0];
            cal_year = yr[15:0];
        end else begin
            // load as given, no range check
            n_sets++;
            cal_year = req.set_year;
            cal_month = req.set_month;
            cal_day = req.set_day;
            cal_hour = req.set_hour;
            cal_minute = req.set_minute;
            cal_second = req.set_second;
            cal_ms = req.set_millisecond;
        end
        rd.now_year = cal_year;
        rd.now_month = cal_month;
        rd.now_day = cal_day;
        rd.now_hour = cal_hour;
        rd.now_minute = cal_minute;
        rd.now_second = cal_second;
        rd.now_millisecond = cal_ms;
        rd.run_days = up_days;
        rd.run_hours = up_hours;
        rd.run_minutes = up_minutes;
        rd.run_seconds = up_seconds;
        rd.run_milliseconds = up_ms;
        return rd;
    endfunction

    // three stretches: sender light / receiver heavy, swapped, then none
    function automatic int unsigned idle_pct(input bit sender_side);
        if (n_accepted < total_requests / 3) return sender_side ? 18 : 73;
        if (n_accepted < 2 * total_requests / 3) return sender_side ? 73 : 18;
        return 0;
    endfunction

    // unused fields carry random noise
    task automatic queue_tick(input int unsigned delta);
        t_clock_request req;
        req = t_clock_request'({$urandom, $urandom, $urandom});
        req.cmd = CMD_TICK;
        req.delta_ms = 16'(delta);
        requests_pending.push_back(req);
    endtask

    task automatic queue_set(input int unsigned yr, input int unsigned mo,
                             input int unsigned dy, input int unsigned hr,
                             input int unsigned mn, input int unsigned sec,
                             input int unsigned ms);
        t_clock_request req;
        req.cmd = CMD_SET;
        req.delta_ms = 16'($urandom);
        req.set_year = 16'(yr);
        req.set_month = 4'(mo);
        req.set_day = 5'(dy);
        req.set_hour = 5'(hr);
        req.set_minute = 6'(mn);
        req.set_second = 6'(sec);
        req.set_millisecond = 10'(ms);
        requests_pending.push_back(req);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                clock_readings_due.push_back(advance_clocks(request_on_bus));
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (requests_pending.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    request_on_bus = requests_pending.pop_front();
                    i_valid <= 1'b1;
                    i_cmd <= request_on_bus.cmd;
                    i_delta_ms <= request_on_bus.delta_ms;
                    i_set_year <= request_on_bus.set_year;
                    i_set_month <= request_on_bus.set_month;
                    i_set_day <= request_on_bus.set_day;
                    i_set_hour <= request_on_bus.set_hour;
                    i_set_minute <= request_on_bus.set_minute;
                    i_set_second <= request_on_bus.set_second;
                    i_set_millisecond <= request_on_bus.set_millisecond;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_clock_reading want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (clock_readings_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d",
                             $time, o_now_year, o_now_month, o_now_day);
                    n_errors++;
                end else begin
                    want = clock_readings_due.pop_front();
                    check_field("now_year", want.now_year, o_now_year);
                    check_field("now_month", want.now_month, o_now_month);
                    check_field("now_day", want.now_day, o_now_day);
                    check_field("now_hour", want.now_hour, o_now_hour);
                    check_field("now_minute", want.now_minute, o_now_minute);
                    check_field("now_second", want.now_second, o_now_second);
                    check_field("now_millisecond", want.now_millisecond, o_now_millisecond);
                    check_field("run_days", want.run_days, o_run_days);
                    check_field("run_hours", want.run_hours, o_run_hours);
                    check_field("run_minutes", want.run_minutes, o_run_minutes);
                    check_field("run_seconds", want.run_seconds, o_run_seconds);
                    check_field("run_milliseconds", want.run_milliseconds,
                                o_run_milliseconds);
                    n_checked++;
                end
            end
            i_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    always @(posedge i_clk) begin : watchdog
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d of %0d requests checked", $time, n_checked,
                     total_requests);
            $display("FAIL");
            $finish;
        end
    end

    initial begin : run_control
        int unsigned roll, sel, yr, mo, last_day;
        // directed: carry edges, leap rule, wraps, unchecked loads
        queue_tick(0);
        queue_tick(999);
        queue_tick(1);
        queue_tick(16'hFFFF);
        queue_set(2024, 2, 28, 23, 59, 59, 999);
        queue_tick(1);
        queue_set(2024, 2, 29, 23, 59, 59, 999);
        queue_tick(1);
        queue_set(2023, 2, 28, 23, 59, 59, 500);
        queue_tick(600);
        queue_set(2100, 2, 28, 23, 59, 59, 999);
        queue_tick(1);
        queue_set(2023, 4, 30, 23, 59, 30, 0);
        queue_tick(30000);
        queue_set(16'hFFFF, 12, 31, 23, 59, 59, 999);
        queue_tick(1);
        queue_set(100, 15, 31, 23, 59, 59, 999);
        queue_tick(1);
        queue_set(100, 0, 31, 23, 59, 59, 999);
        queue_tick(1);
        queue_set(16'hFFFF, 15, 31, 31, 63, 63, 1023);
        queue_tick(16'hFFFF);
        queue_set(0, 0, 0, 0, 0, 0, 0);
        queue_tick(0);
        queue_set(2023, 6, 15, 31, 0, 0, 1023);
        queue_tick(0);

        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                sel = $urandom_range(3);
                case (sel)
                    0:       queue_tick($urandom_range(999));
                    1:       queue_tick($urandom_range(65535));
                    2:       queue_tick(65535 - $urandom_range(500));
                    default: queue_tick(1000 * $urandom_range(65));
                endcase
            end else if (roll < 90) begin
                // valid date just before midnight on a month's last day or the day before, so ticks roll it
                yr = $urandom_range(65535);
                if ($urandom_range(1) == 0) yr = yr & 32'hFFFC;
                mo = $urandom_range(12, 1);
                last_day = month_length(mo);
                if (mo == 32'(MONTH_FEB) && yr[1:0] == 2'd0) last_day = LEAP_FEB_LIMIT - 1;
                queue_set(yr, mo, last_day - $urandom_range(1), 23, 59,
                          $urandom_range(59, 50), $urandom_range(999));
            end else begin
                queue_set($urandom_range(65535), $urandom_range(15), $urandom_range(31),
                          $urandom_range(31), $urandom_range(63), $urandom_range(63),
                          $urandom_range(1023));
            end
        end
        total_requests = requests_pending.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < total_requests || clock_readings_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d ticks, %0d loads, %0d day carries,", n_checked,
                 n_ticks, n_sets, n_day_rolls);
        $display("  %0d month rollovers, %0d year rollovers, %0d leap days reached.",
                 n_month_rolls, n_year_rolls, n_leap_days);
        if (n_errors == 0 && clock_readings_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/cauc_pkg.sv
design/cauc_carry.sv
design/calendar_and_uptime_clock_unit.sv
tb/tb_calendar_and_uptime_clock_unit.sv
